// File: src/radix2_twiddle_butterfly_unit_macros.svh
// ----------------------------------------------------------------------------
// radix2 twiddle butterfly assertion macros
// shared assertion forms for the butterfly unit
// ----------------------------------------------------------------------------
`ifndef RADIX2_TWIDDLE_BUTTERFLY_UNIT_MACROS_SVH
`define RADIX2_TWIDDLE_BUTTERFLY_UNIT_MACROS_SVH

// same-cycle implication
`define R2B_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define R2B_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/r2bfly_pkg.sv
// ----------------------------------------------------------------------------
// r2bfly_pkg
// constants, types and the twiddle octant generator for the butterfly unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package r2bfly_pkg;

   // angle resolution of one full turn, in bits
   localparam int AngleBits = 16;
   localparam logic [AngleBits-1:0] HalfTurn    = 16'd32768;
   localparam logic [AngleBits-1:0] QuarterTurn = 16'd16384;
   localparam logic [AngleBits-1:0] EighthTurn  = 16'd8192;

   // twiddle format q2.16 and octant magnitude width
   localparam int TwidW     = 18;
   localparam int MagW      = 17;
   localparam int FracShift = 16;

   // fixed field and register widths
   localparam int IndexW   = 9;
   localparam int SizeW    = 4;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 8;

   // pi in q31
   localparam logic [63:0] PiQ31 = 64'd6746518852;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_SIZE_LOG2    = 4'd0,
      CSR_INVERSE_MODE = 4'd1
   } csr_reg_type;

   typedef struct packed {
      logic [MagW-1:0] cos_mag;
      logic [MagW-1:0] sin_mag;
   } twid_mag_type;

   // cos and sin magnitudes of 2*pi*r/2^16 for r up to an eighth turn,
   // seven-term series in q31, rounded to 16 fraction bits
   function automatic twid_mag_type twiddle_octant(input logic [63:0] r);
      logic [63:0]        th;
      logic [63:0]        x2;
      logic [63:0]        ts;
      logic [63:0]        tc;
      logic signed [63:0] ss;
      logic signed [63:0] cs;
      twid_mag_type       res;
      th = (PiQ31 * r + 64'd16384) >> 15;
      x2 = (th * th) >> 31;
      ts = th;
      tc = 64'd1 << 31;
      ss = $signed(th);
      cs = $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd6;
      tc = ((tc * x2) >> 31) / 64'd2;
      ss = ss - $signed(ts);
      cs = cs - $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd20;
      tc = ((tc * x2) >> 31) / 64'd12;
      ss = ss + $signed(ts);
      cs = cs + $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd42;
      tc = ((tc * x2) >> 31) / 64'd30;
      ss = ss - $signed(ts);
      cs = cs - $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd72;
      tc = ((tc * x2) >> 31) / 64'd56;
      ss = ss + $signed(ts);
      cs = cs + $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd110;
      tc = ((tc * x2) >> 31) / 64'd90;
      ss = ss - $signed(ts);
      cs = cs - $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd156;
      tc = ((tc * x2) >> 31) / 64'd132;
      ss = ss + $signed(ts);
      cs = cs + $signed(tc);
      ts = ((ts * x2) >> 31) / 64'd210;
      tc = ((tc * x2) >> 31) / 64'd182;
      ss = ss - $signed(ts);
      cs = cs - $signed(tc);
      if (ss < 0) ss = 64'sd0;
      if (cs < 0) cs = 64'sd0;
      res.cos_mag = MagW'((64'(cs) + 64'd16384) >> 15);
      res.sin_mag = MagW'((64'(ss) + 64'd16384) >> 15);
      return res;
   endfunction

endpackage

// File: src/r2bfly_req_if.sv
// ----------------------------------------------------------------------------
// r2bfly_req_if
// input channel: butterfly index and the two complex points
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface r2bfly_req_if
   import r2bfly_pkg::*;
#(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic [IndexW-1:0]            pair_index;
   logic signed [DATA_WIDTH-1:0] upper_real;
   logic signed [DATA_WIDTH-1:0] upper_imag;
   logic signed [DATA_WIDTH-1:0] lower_real;
   logic signed [DATA_WIDTH-1:0] lower_imag;

   modport source (
      output valid, pair_index, upper_real, upper_imag, lower_real, lower_imag,
      input  ready
   );
   modport sink (
      input  valid, pair_index, upper_real, upper_imag, lower_real, lower_imag,
      output ready
   );
endinterface

// File: src/r2bfly_rsp_if.sv
// ----------------------------------------------------------------------------
// r2bfly_rsp_if
// result channel: sum and difference of the butterfly
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface r2bfly_rsp_if #(
   parameter int DATA_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic signed [DATA_WIDTH+1:0]   sum_real;
   logic signed [DATA_WIDTH+1:0]   sum_imag;
   logic signed [DATA_WIDTH+1:0]   diff_real;
   logic signed [DATA_WIDTH+1:0]   diff_imag;

   modport source (
      output valid, sum_real, sum_imag, diff_real, diff_imag,
      input  ready
   );
   modport sink (
      input  valid, sum_real, sum_imag, diff_real, diff_imag,
      output ready
   );
endinterface

// File: src/r2bfly_csr_if.sv
// ----------------------------------------------------------------------------
// r2bfly_csr_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface r2bfly_csr_if
   import r2bfly_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [CsrAddrW-1:0] index;
   logic [CsrDataW-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// File: src/radix2_twiddle_butterfly_unit.sv
// ----------------------------------------------------------------------------
// radix2_twiddle_butterfly_unit: radix-2 dit combine butterfly, twiddle rom
// pipeline: six stages, angle, octant fold, twiddle, products, rotation, output register
// throughput: one butterfly per cycle; each stage holds only when stalled
// reset: synchronous, clears valid bits and restores size_log2 10, forward
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "radix2_twiddle_butterfly_unit_macros.svh"

module radix2_twiddle_butterfly_unit
   import r2bfly_pkg::*;
#(
   parameter int MAX_SIZE_LOG2 = 10,
   parameter int DATA_WIDTH    = 16
) (
   input  logic         clock,
   input  logic         reset,
   r2bfly_req_if.sink   req_chan,
   r2bfly_rsp_if.source rsp_chan,
   r2bfly_csr_if.sink   csr_chan
);

   // derived sizes
   localparam int OctBits  = (MAX_SIZE_LOG2 >= 3) ? MAX_SIZE_LOG2 - 3 : 0;
   localparam int RomDepth = (2 ** OctBits) + 1;
   localparam int RomIdxW  = OctBits + 1;
   localparam int RomShift = AngleBits - 3 - OctBits;
   localparam int ProdW    = DATA_WIDTH + TwidW;
   localparam int AccW     = ProdW + 1;
   localparam int RotW     = AccW - FracShift;
   localparam int OutW     = DATA_WIDTH + 2;
   localparam int Stages   = 6;

   localparam logic [4:0]            MaxSize   = 5'(MAX_SIZE_LOG2);
   localparam logic [4:0]            AngleSh   = 5'(AngleBits);
   localparam logic signed [AccW-1:0] RoundHalf = AccW'(32768);
   localparam logic signed [TwidW-1:0] TwidOne  = 18'sd65536;

   // configuration registers
   logic [SizeW-1:0] size_log2_ff;
   logic             inverse_ff;

   // pipeline control
   logic [Stages:1] vld_ff;
   logic [Stages:1] vld_in;
   logic [Stages:1] rdy;

   // carried points
   logic signed [DATA_WIDTH-1:0] x_re_ff [1:5];
   logic signed [DATA_WIDTH-1:0] x_im_ff [1:5];
   logic signed [DATA_WIDTH-1:0] y_re_ff [1:3];
   logic signed [DATA_WIDTH-1:0] y_im_ff [1:3];

   // stage 1: angle
   logic [4:0]           size_eff;
   logic [IndexW-1:0]    k_mask;
   logic [AngleBits-1:0] m1_in;
   logic [AngleBits-1:0] m1_ff;

   // stage 2: octant fold
   logic [AngleBits-1:0] r_half;
   logic [AngleBits-1:0] r_oct;
   logic                 neg2_in;
   logic                 swap2_in;
   logic                 neg2_ff;
   logic                 swap2_ff;
   logic [RomIdxW-1:0]   idx2_ff;

   // stage 3: twiddle
   logic [MagW-1:0]         rom_cos [RomDepth];
   logic [MagW-1:0]         rom_sin [RomDepth];
   logic [TwidW-1:0]        cm_ext;
   logic [TwidW-1:0]        sm_ext;
   logic signed [TwidW-1:0] wr3_in;
   logic signed [TwidW-1:0] wi3_in;
   logic signed [TwidW-1:0] wr3_ff;
   logic signed [TwidW-1:0] wi3_ff;

   // stage 4: partial products
   logic signed [ProdW-1:0] p_rr_ff;
   logic signed [ProdW-1:0] p_ii_ff;
   logic signed [ProdW-1:0] p_ri_ff;
   logic signed [ProdW-1:0] p_ir_ff;

   // stage 5: rounded rotation
   logic signed [AccW-1:0] acc_re;
   logic signed [AccW-1:0] acc_im;
   logic signed [RotW-1:0] t_re5_ff;
   logic signed [RotW-1:0] t_im5_ff;

   // stage 6: output register
   logic signed [OutW-1:0] sum_re6_ff;
   logic signed [OutW-1:0] sum_im6_ff;
   logic signed [OutW-1:0] diff_re6_ff;
   logic signed [OutW-1:0] diff_im6_ff;

   // register writes, unknown indexes ignored
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= 4'd10;
         inverse_ff   <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_reg_type'(csr_chan.index))
            CSR_SIZE_LOG2:    size_log2_ff <= csr_chan.data[SizeW-1:0];
            CSR_INVERSE_MODE: inverse_ff   <= csr_chan.data[0];
            default:          ;
         endcase
      end
   end

   // stage ready chain, bubbles fill behind a stalled output
   always_comb begin
      rdy[Stages] = !vld_ff[Stages] || rsp_chan.ready;
      for (int i = Stages - 1; i >= 1; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[1] = rdy[1] ? req_chan.valid : vld_ff[1];
      for (int i = 2; i <= Stages; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_chan.ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // clamp size, mask index, scale to a 16-bit angle
   always_comb begin
      size_eff = {1'b0, size_log2_ff};
      if (size_eff == 5'd0) size_eff = 5'd1;
      if (size_eff > MaxSize) size_eff = MaxSize;
      k_mask = IndexW'((17'd1 << (size_eff - 5'd1)) - 17'd1);
      m1_in  = AngleBits'(req_chan.pair_index & k_mask) << (AngleSh - size_eff);
   end

   // fold the angle into the first octant
   always_comb begin
      neg2_in  = m1_ff > QuarterTurn;
      r_half   = neg2_in ? HalfTurn - m1_ff : m1_ff;
      swap2_in = r_half > EighthTurn;
      r_oct    = swap2_in ? QuarterTurn - r_half : r_half;
   end

   // octant rom, built at elaboration
   for (genvar gi = 0; gi < RomDepth; gi++) begin : g_rom
      localparam twid_mag_type Entry = twiddle_octant(64'(gi) << RomShift);
      assign rom_cos[gi] = Entry.cos_mag;
      assign rom_sin[gi] = Entry.sin_mag;
   end

   // rom read, octant swap, signs and conjugate
   always_comb begin
      cm_ext = TwidW'(swap2_ff ? rom_sin[idx2_ff] : rom_cos[idx2_ff]);
      sm_ext = TwidW'(swap2_ff ? rom_cos[idx2_ff] : rom_sin[idx2_ff]);
      wr3_in = neg2_ff ? TwidW'(TwidW'(0) - cm_ext) : cm_ext;
      wi3_in = inverse_ff ? sm_ext : TwidW'(TwidW'(0) - sm_ext);
   end

   // combine products and round to 15 fraction bits
   always_comb begin
      acc_re = AccW'(p_rr_ff) - AccW'(p_ii_ff) + RoundHalf;
      acc_im = AccW'(p_ri_ff) + AccW'(p_ir_ff) + RoundHalf;
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         m1_ff      <= m1_in;
         x_re_ff[1] <= req_chan.upper_real;
         x_im_ff[1] <= req_chan.upper_imag;
         y_re_ff[1] <= req_chan.lower_real;
         y_im_ff[1] <= req_chan.lower_imag;
      end
      if (rdy[2]) begin
         neg2_ff    <= neg2_in;
         swap2_ff   <= swap2_in;
         idx2_ff    <= r_oct[AngleBits-3:RomShift];
         x_re_ff[2] <= x_re_ff[1];
         x_im_ff[2] <= x_im_ff[1];
         y_re_ff[2] <= y_re_ff[1];
         y_im_ff[2] <= y_im_ff[1];
      end
      if (rdy[3]) begin
         wr3_ff     <= wr3_in;
         wi3_ff     <= wi3_in;
         x_re_ff[3] <= x_re_ff[2];
         x_im_ff[3] <= x_im_ff[2];
         y_re_ff[3] <= y_re_ff[2];
         y_im_ff[3] <= y_im_ff[2];
      end
      if (rdy[4]) begin
         p_rr_ff    <= ProdW'(y_re_ff[3]) * ProdW'(wr3_ff);
         p_ii_ff    <= ProdW'(y_im_ff[3]) * ProdW'(wi3_ff);
         p_ri_ff    <= ProdW'(y_re_ff[3]) * ProdW'(wi3_ff);
         p_ir_ff    <= ProdW'(y_im_ff[3]) * ProdW'(wr3_ff);
         x_re_ff[4] <= x_re_ff[3];
         x_im_ff[4] <= x_im_ff[3];
      end
      if (rdy[5]) begin
         t_re5_ff   <= acc_re[AccW-1:FracShift];
         t_im5_ff   <= acc_im[AccW-1:FracShift];
         x_re_ff[5] <= x_re_ff[4];
         x_im_ff[5] <= x_im_ff[4];
      end
      if (rdy[6]) begin
         sum_re6_ff  <= OutW'(x_re_ff[5]) + OutW'(t_re5_ff);
         sum_im6_ff  <= OutW'(x_im_ff[5]) + OutW'(t_im5_ff);
         diff_re6_ff <= OutW'(x_re_ff[5]) - OutW'(t_re5_ff);
         diff_im6_ff <= OutW'(x_im_ff[5]) - OutW'(t_im5_ff);
      end
   end

   // result channel
   assign rsp_chan.valid     = vld_ff[Stages];
   assign rsp_chan.sum_real  = sum_re6_ff;
   assign rsp_chan.sum_imag  = sum_im6_ff;
   assign rsp_chan.diff_real = diff_re6_ff;
   assign rsp_chan.diff_imag = diff_im6_ff;

   // checks
   `R2B_ASSERT_IMPL(a_angle_below_half, clock, reset, vld_ff[1], m1_ff < HalfTurn, "angle beyond half turn")
   `R2B_ASSERT_IMPL(a_twiddle_bounded, clock, reset, vld_ff[3], (wr3_ff <= TwidOne) && (wr3_ff >= -TwidOne) && (wi3_ff <= TwidOne) && (wi3_ff >= -TwidOne), "twiddle out of range")
   `R2B_ASSERT_NEXT(a_stall_holds, clock, reset, vld_ff[5] && !rdy[6], vld_ff[5] && $stable(t_re5_ff) && $stable(t_im5_ff), "stalled stage lost its item")
   `R2B_ASSERT_NEXT(a_transfer_enters, clock, reset, req_chan.valid && req_chan.ready, vld_ff[1], "input transfer not captured")

endmodule

// File: tb/tb_radix2_twiddle_butterfly_unit.sv
// ----------------------------------------------------------------------------
// tb_radix2_twiddle_butterfly_unit
// self-checking bench for the radix-2 twiddle butterfly: a directed set of
// corner points, then random butterflies over many size and direction
// settings, with random stalls on both channels; every result is compared
// against an in-bench twiddle and butterfly calculation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radix2_twiddle_butterfly_unit;
   import r2bfly_pkg::*;

   localparam int DataW          = 16;
   localparam int OutW           = DataW + 2;
   localparam int MaxSizeLog2    = 10;
   localparam int ResetSizeLog2  = 10;
   localparam int ClockPeriod    = 20;
   localparam int ResetCycles    = 9;
   localparam int PipeLatency    = 6;
   localparam int PhaseItems     = 96;
   localparam int PhaseCount     = 16;
   localparam int LongHoldCycles = 200;
   localparam int TimeoutNs      = 5_000_000;
   localparam int CsrIndexCount  = 1 << CsrAddrW;
   localparam int CsrFirstUnused = int'(CSR_INVERSE_MODE) + 1;
   localparam logic signed [DataW-1:0] SampleMax = {1'b0, {(DataW-1){1'b1}}};
   localparam logic signed [DataW-1:0] SampleMin = {1'b1, {(DataW-1){1'b0}}};

   typedef struct {
      logic [IndexW-1:0]       pair_index;
      logic signed [DataW-1:0] upper_real;
      logic signed [DataW-1:0] upper_imag;
      logic signed [DataW-1:0] lower_real;
      logic signed [DataW-1:0] lower_imag;
   } butterfly_in_type;

   typedef struct {
      logic signed [OutW-1:0] sum_real;
      logic signed [OutW-1:0] sum_imag;
      logic signed [OutW-1:0] diff_real;
      logic signed [OutW-1:0] diff_imag;
   } butterfly_out_type;

   // expected butterfly results and the register copy they depend on
   class butterfly_scoreboard;
      butterfly_out_type expected_results[$];
      logic [SizeW-1:0]  size_log2;
      logic              inverse_mode;
      int                fail_count;

      function new();
         size_log2    = SizeW'(ResetSizeLog2);
         inverse_mode = 1'b0;
         fail_count   = 0;
      endfunction

      function void apply_register(logic [CsrAddrW-1:0] idx, logic [CsrDataW-1:0] value);
         if (idx == CSR_SIZE_LOG2) size_log2 = value[SizeW-1:0];
         else if (idx == CSR_INVERSE_MODE) inverse_mode = value[0];
      endfunction

      // seven-term taylor series for cos and sin, all in q31
      function void taylor_cos_sin(input logic [63:0] angle, output logic [63:0] cos_q31,
                                   output logic [63:0] sin_q31);
         logic [63:0] sq;
         logic [63:0] sin_term;
         logic [63:0] cos_term;
         logic [63:0] sin_div;
         logic [63:0] cos_div;
         longint      sin_acc;
         longint      cos_acc;
         sq       = (angle * angle) >> 31;
         sin_term = angle;
         cos_term = 64'd1 << 31;
         sin_acc  = longint'(sin_term);
         cos_acc  = longint'(cos_term);
         for (int n = 1; n <= 7; n++) begin
            sin_div  = 64'((2 * n) * (2 * n + 1));
            cos_div  = 64'((2 * n - 1) * (2 * n));
            sin_term = ((sin_term * sq) >> 31) / sin_div;
            cos_term = ((cos_term * sq) >> 31) / cos_div;
            if (n % 2 == 1) begin
               sin_acc -= longint'(sin_term);
               cos_acc -= longint'(cos_term);
            end else begin
               sin_acc += longint'(sin_term);
               cos_acc += longint'(cos_term);
            end
         end
         if (sin_acc < 0) sin_acc = 0;
         if (cos_acc < 0) cos_acc = 0;
         cos_q31 = 64'(cos_acc);
         sin_q31 = 64'(sin_acc);
      endfunction

      // q2.16 cos and sin of a half-turn angle, folded into the first octant
      function void twiddle_q216(input logic [AngleBits-1:0] angle_idx, output longint w_cos,
                                 output longint w_sin);
         logic [63:0] r;
         logic [63:0] theta;
         logic [63:0] cos_q31;
         logic [63:0] sin_q31;
         logic [63:0] cos_mag;
         logic [63:0] sin_mag;
         logic [63:0] tmp;
         bit          neg_cos;
         bit          swap;
         r       = 64'(angle_idx);
         neg_cos = 1'b0;
         swap    = 1'b0;
         if (r > 64'(QuarterTurn)) begin
            r       = 64'(HalfTurn) - r;
            neg_cos = 1'b1;
         end
         if (r > 64'(EighthTurn)) begin
            r    = 64'(QuarterTurn) - r;
            swap = 1'b1;
         end
         theta = (PiQ31 * r + 64'd16384) >> 15;
         taylor_cos_sin(theta, cos_q31, sin_q31);
         cos_mag = (cos_q31 + 64'd16384) >> 15;
         sin_mag = (sin_q31 + 64'd16384) >> 15;
         if (swap) begin
            tmp     = cos_mag;
            cos_mag = sin_mag;
            sin_mag = tmp;
         end
         w_cos = neg_cos ? -longint'(cos_mag) : longint'(cos_mag);
         w_sin = longint'(sin_mag);
      endfunction

      function butterfly_out_type predict_butterfly(butterfly_in_type it);
         int unsigned          eff_size;
         logic [IndexW-1:0]    k;
         logic [AngleBits-1:0] angle_idx;
         longint               xr, xi, yr, yi;
         longint               w_cos, w_sin, w_imag;
         longint               prod_real, prod_imag;
         butterfly_out_type    res;
         eff_size = size_log2;
         if (eff_size < 1) eff_size = 1;
         if (eff_size > MaxSizeLog2) eff_size = MaxSizeLog2;
         // index wraps modulo n/2
         k         = it.pair_index & IndexW'((1 << (eff_size - 1)) - 1);
         angle_idx = AngleBits'(k) << (AngleBits - eff_size);
         twiddle_q216(angle_idx, w_cos, w_sin);
         w_imag = inverse_mode ? w_sin : -w_sin;
         xr = it.upper_real;
         xi = it.upper_imag;
         yr = it.lower_real;
         yi = it.lower_imag;
         // round to 15 fraction bits: add half lsb, floor shift
         prod_real = (yr * w_cos - yi * w_imag + (64'sd1 <<< 15)) >>> FracShift;
         prod_imag = (yr * w_imag + yi * w_cos + (64'sd1 <<< 15)) >>> FracShift;
         res.sum_real  = OutW'(xr + prod_real);
         res.sum_imag  = OutW'(xi + prod_imag);
         res.diff_real = OutW'(xr - prod_real);
         res.diff_imag = OutW'(xi - prod_imag);
         return res;
      endfunction

      function void note_accepted(butterfly_in_type it);
         expected_results.push_back(predict_butterfly(it));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void compare_field(string name, logic signed [OutW-1:0] exp_val,
                                  logic signed [OutW-1:0] got_val);
         if (got_val !== exp_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            fail_count++;
         end
      endfunction

      function void check_result(butterfly_out_type got);
         butterfly_out_type exp_res;
         if (expected_results.size() == 0) begin
            $error("result transfer with no expected result pending");
            fail_count++;
            return;
         end
         exp_res = expected_results.pop_front();
         compare_field("sum_real", exp_res.sum_real, got.sum_real);
         compare_field("sum_imag", exp_res.sum_imag, got.sum_imag);
         compare_field("diff_real", exp_res.diff_real, got.diff_real);
         compare_field("diff_imag", exp_res.diff_imag, got.diff_imag);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   r2bfly_req_if #(.DATA_WIDTH(DataW)) req_chan ();
   r2bfly_rsp_if #(.DATA_WIDTH(DataW)) rsp_chan ();
   r2bfly_csr_if                       csr_chan ();

   radix2_twiddle_butterfly_unit #(
      .MAX_SIZE_LOG2 (MaxSizeLog2),
      .DATA_WIDTH    (DataW)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   butterfly_scoreboard sb = new();

   int                sender_idle_pct;
   int                receiver_idle_pct;
   bit                long_hold_pending;
   int                hold_count;
   butterfly_out_type seen_result;

   // clock
   always #(ClockPeriod / 2) clock = ~clock;

   // watchdog
   initial begin
      #(TimeoutNs);
      $display("FAILURE");
      $finish;
   end

   // result side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_result.sum_real  = rsp_chan.sum_real;
            seen_result.sum_imag  = rsp_chan.sum_imag;
            seen_result.diff_real = rsp_chan.diff_real;
            seen_result.diff_imag = rsp_chan.diff_imag;
            sb.check_result(seen_result);
         end
         if (long_hold_pending) begin
            hold_count        = LongHoldCycles;
            long_hold_pending = 1'b0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   // register write; valid stays up for back-to-back writes
   task automatic write_register(input logic [CsrAddrW-1:0] idx,
                                 input logic [CsrDataW-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      sb.apply_register(idx, value);
   endtask

   // write both registers plus one unused index, junk in the spare data bits
   task automatic program_registers(input logic [SizeW-1:0] size, input logic inverse);
      logic [CsrDataW-1:0] value;
      value            = CsrDataW'($urandom);
      value[SizeW-1:0] = size;
      write_register(CSR_SIZE_LOG2, value);
      value    = CsrDataW'($urandom);
      value[0] = inverse;
      write_register(CSR_INVERSE_MODE, value);
      write_register(CsrAddrW'($urandom_range(CsrFirstUnused, CsrIndexCount - 1)),
                     CsrDataW'($urandom));
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // one butterfly transfer, with random idle cycles ahead of it
   task automatic send_butterfly(input butterfly_in_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.pair_index <= it.pair_index;
      req_chan.upper_real <= it.upper_real;
      req_chan.upper_imag <= it.upper_imag;
      req_chan.lower_real <= it.lower_real;
      req_chan.lower_imag <= it.lower_imag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_accepted(it);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   function automatic butterfly_in_type make_butterfly(int k, int xr, int xi, int yr, int yi);
      butterfly_in_type it;
      it.pair_index = IndexW'(k);
      it.upper_real = DataW'(xr);
      it.upper_imag = DataW'(xi);
      it.lower_real = DataW'(yr);
      it.lower_imag = DataW'(yi);
      return it;
   endfunction

   // mostly random samples, now and then a full-scale or near-zero value
   function automatic logic signed [DataW-1:0] pick_sample();
      case ($urandom_range(0, 11))
         0: return SampleMax;
         1: return SampleMin;
         2: return '0;
         3: return '1;
         default: return DataW'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      logic [SizeW-1:0] phase_size [PhaseCount];
      logic             phase_inv  [PhaseCount];
      butterfly_in_type directed_q[$];
      butterfly_in_type it;

      phase_size = '{4'd10, 4'd10, 4'd1, 4'd1, 4'd0, 4'd15, 4'd2, 4'd3,
                     4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd11, 4'd12};
      phase_inv  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                     1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.pair_index = '0;
      req_chan.upper_real = '0;
      req_chan.upper_imag = '0;
      req_chan.lower_real = '0;
      req_chan.lower_imag = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = '0;
      csr_chan.data       = '0;
      sender_idle_pct     = 28;
      receiver_idle_pct   = 58;
      long_hold_pending   = 1'b0;
      hold_count          = 0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner points at the reset setting: n = 1024, forward
      directed_q.push_back(make_butterfly(0, 0, 0, 32767, 32767));
      directed_q.push_back(make_butterfly(0, 32767, 32767, 32767, 32767));
      directed_q.push_back(make_butterfly(0, -32768, -32768, -32768, -32768));
      directed_q.push_back(make_butterfly(0, 32767, -32768, -32768, 32767));
      directed_q.push_back(make_butterfly(128, 32767, 32767, 32767, -32768));
      directed_q.push_back(make_butterfly(128, -32768, -32768, -32768, -32768));
      directed_q.push_back(make_butterfly(256, 32767, 32767, -32768, 32767));
      directed_q.push_back(make_butterfly(256, -32768, 0, -32768, -32768));
      directed_q.push_back(make_butterfly(384, 32767, -32768, 32767, 32767));
      directed_q.push_back(make_butterfly(511, -32768, 32767, -32768, 32767));
      directed_q.push_back(make_butterfly(511, 0, 0, 32767, -32768));
      directed_q.push_back(make_butterfly(64, 1000, -1000, 32767, 32767));
      directed_q.push_back(make_butterfly(1, -1, -1, 1, 1));
      directed_q.push_back(make_butterfly(255, 12345, -23456, -32768, 32767));
      directed_q.push_back(make_butterfly(257, -1, 1, -1, 1));
      directed_q.push_back(make_butterfly(170, 0, 0, 0, 0));
      directed_q.push_back(make_butterfly(341, 32767, 32767, 32767, 32767));
      foreach (directed_q[i]) send_butterfly(directed_q[i]);
      wait_results_drained();

      // random phases over sizes, the out-of-range ones included, and both directions
      for (int p = 0; p < PhaseCount; p++) begin
         if (p == 5) begin
            sender_idle_pct   = 58;
            receiver_idle_pct = 28;
         end else if (p == 11) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         program_registers(phase_size[p], phase_inv[p]);
         for (int i = 0; i < PhaseItems; i++) begin
            // long result stall while input keeps coming, fills the pipe
            if (p == 3 && i == 10) long_hold_pending = 1'b1;
            // sender pause until the pipe is empty
            if (p == 7 && i == PhaseItems / 2) wait_results_drained();
            it.pair_index = IndexW'($urandom);
            it.upper_real = pick_sample();
            it.upper_imag = pick_sample();
            it.lower_real = pick_sample();
            it.lower_imag = pick_sample();
            send_butterfly(it);
         end
         wait_results_drained();
      end

      if (sb.fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: radix2_twiddle_butterfly_unit.f
+incdir+src
src/r2bfly_pkg.sv
src/r2bfly_req_if.sv
src/r2bfly_rsp_if.sv
src/r2bfly_csr_if.sv
src/radix2_twiddle_butterfly_unit.sv
tb/tb_radix2_twiddle_butterfly_unit.sv
